// ===== sv/line_sensor_steering_pd_core_assert.svh =====
// Assertion macros for the line sensor steering block.
// Clocked on clk, disabled while rst_n is low; both must be in scope at the use.
`ifndef LINE_SENSOR_STEERING_PD_CORE_ASSERT_SVH
`define LINE_SENSOR_STEERING_PD_CORE_ASSERT_SVH

// same-cycle implication
`define LSPD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LSPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lspd_pkg.sv =====
// Shared types, constants and helpers for the line sensor steering block.
// No dependencies; used by the core and its checker.
package lspd_pkg;

  localparam int NUM_SENSORS = 8;
  localparam int DRIVE_W     = 8;
  localparam int ERR_W       = 5;
  localparam int CNT_W       = 4;
  localparam int THR_W       = 4;
  localparam int CFG_DATA_W  = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int ADJ_W       = 8;   // holds +-72
  localparam int SUM_W       = 10;  // holds -72..327

  localparam logic [CFG_IDX_W-1:0] REG_OUTER_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_BASE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_THRESH = 2'd2;

  localparam logic [DRIVE_W-1:0] OUTER_BASE_RST  = 8'd42;
  localparam logic [DRIVE_W-1:0] INNER_BASE_RST  = 8'd40;
  localparam logic [THR_W-1:0]   MARK_THRESH_RST = 4'd4;

  localparam logic MODE_OUTER = 1'b0;
  localparam logic MODE_INNER = 1'b1;

  localparam logic [CNT_W-1:0] MAX_DARK = 4'd8;
  localparam int               ERR_MAX  = 12;

  typedef logic [2:0] sens_idx_t;             // sensor number minus one
  typedef logic signed [ERR_W-1:0] err_t;

  // priority order, first dark sensor wins
  localparam sens_idx_t OUTER_ORDER [NUM_SENSORS] = '{3'd3, 3'd4, 3'd2, 3'd5,
                                                      3'd6, 3'd1, 3'd7, 3'd0};
  localparam err_t OUTER_WEIGHT [NUM_SENSORS] = '{5'sd1, -5'sd1, 5'sd3, -5'sd3,
                                                  -5'sd5, 5'sd5, -5'sd7, 5'sd7};
  localparam sens_idx_t INNER_ORDER [NUM_SENSORS] = '{3'd3, 3'd4, 3'd2, 3'd5,
                                                      3'd1, 3'd6, 3'd0, 3'd7};
  localparam err_t INNER_WEIGHT [NUM_SENSORS] = '{5'sd5, -5'sd5, 5'sd9, -5'sd9,
                                                  5'sd11, -5'sd11, 5'sd12, -5'sd12};

  function automatic logic [DRIVE_W-1:0] sat_drive(input logic signed [SUM_W-1:0] v);
    logic [DRIVE_W-1:0] r;
    if (v[SUM_W-1]) begin
      r = '0;
    end else if (v[SUM_W-2:DRIVE_W] != '0) begin
      r = '1;
    end else begin
      r = v[DRIVE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/line_sensor_steering_pd_core.sv =====
// Line sensor steering core: dark-sensor decode, position error and PD drive.
// Depends on lspd_pkg.
//
// One bar reading is accepted per cycle while in_stall is low, and its result
// appears in the output register on the next cycle. Decode, priority pick, PD
// sum and saturation sit between the input ports and that register; the
// previous-error register closes its loop through that logic, which is what
// sets the rate. The input stalls only while a finished result is held by a
// stalled output, and during reset.
module line_sensor_steering_pd_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [lspd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lspd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_sensor_low_byte,
  input  logic [7:0]                         in_sensor_high_byte,
  input  logic                               in_mode,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [lspd_pkg::DRIVE_W-1:0]       out_left_drive,
  output logic [lspd_pkg::DRIVE_W-1:0]       out_right_drive,
  output logic signed [lspd_pkg::ERR_W-1:0]  out_position_error,
  output logic [lspd_pkg::CNT_W-1:0]         out_dark_count,
  output logic                               out_mark_seen
);
  import lspd_pkg::*;

  logic [DRIVE_W-1:0]     outer_base_r, inner_base_r;
  logic [THR_W-1:0]       mark_thresh_r;
  err_t                   prev_err_r, err_nxt;
  logic                   out_valid_r;
  logic [DRIVE_W-1:0]     left_r, right_r, left_nxt, right_nxt;
  err_t                   err_r;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   mark_r, mark_nxt;
  logic [NUM_SENSORS-1:0] dark;
  logic                   accept;
  logic [DRIVE_W-1:0]     base;
  logic signed [ADJ_W-1:0] e_ext, prev_ext, p_term, adj;
  logic signed [SUM_W-1:0] base_ext, adj_ext;

  assign in_stall = !rst_n || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  // bit k of dark is sensor k+1
  always_comb begin
    for (int k = 0; k < NUM_SENSORS - 1; k++) begin
      dark[k] = !in_sensor_high_byte[k+1];
    end
    dark[NUM_SENSORS-1] = (in_sensor_low_byte == '0);
  end

  always_comb begin
    count_nxt = '0;
    for (int k = 0; k < NUM_SENSORS; k++) begin
      count_nxt = count_nxt + CNT_W'(dark[k]);
    end
  end

  // walk from lowest priority up so the highest-priority hit is kept
  always_comb begin
    err_nxt = prev_err_r;
    for (int k = NUM_SENSORS - 1; k >= 0; k--) begin
      if (in_mode == MODE_INNER) begin
        if (dark[INNER_ORDER[k]]) err_nxt = INNER_WEIGHT[k];
      end else begin
        if (dark[OUTER_ORDER[k]]) err_nxt = OUTER_WEIGHT[k];
      end
    end
  end

  always_comb begin
    base     = (in_mode == MODE_INNER) ? inner_base_r : outer_base_r;
    e_ext    = ADJ_W'(err_nxt);
    prev_ext = ADJ_W'(prev_err_r);
    p_term   = (in_mode == MODE_INNER) ? (e_ext <<< 1) : (e_ext <<< 2);
    adj      = p_term + e_ext - prev_ext;
    base_ext = $signed({{(SUM_W-DRIVE_W){1'b0}}, base});
    adj_ext  = SUM_W'(adj);
    left_nxt  = sat_drive(base_ext - adj_ext);
    right_nxt = sat_drive(base_ext + adj_ext);
    mark_nxt  = (count_nxt > mark_thresh_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_base_r  <= OUTER_BASE_RST;
      inner_base_r  <= INNER_BASE_RST;
      mark_thresh_r <= MARK_THRESH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OUTER_BASE:  outer_base_r  <= cfg_data[DRIVE_W-1:0];
        REG_INNER_BASE:  inner_base_r  <= cfg_data[DRIVE_W-1:0];
        REG_MARK_THRESH: mark_thresh_r <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        prev_err_r  <= err_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
      err_r   <= err_nxt;
      count_r <= count_nxt;
      mark_r  <= mark_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_left_drive     = left_r;
  assign out_right_drive    = right_r;
  assign out_position_error = err_r;
  assign out_dark_count     = count_r;
  assign out_mark_seen      = mark_r;

endmodule

// ===== sv/lspd_checker.sv =====
// Port-level checker for the line sensor steering core, bound into the core module.
// Depends on lspd_pkg and line_sensor_steering_pd_core_assert.svh.
`include "line_sensor_steering_pd_core_assert.svh"

module lspd_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [lspd_pkg::DRIVE_W-1:0]       out_left_drive,
  input logic [lspd_pkg::DRIVE_W-1:0]       out_right_drive,
  input logic signed [lspd_pkg::ERR_W-1:0]  out_position_error,
  input logic [lspd_pkg::CNT_W-1:0]         out_dark_count,
  input logic                               out_mark_seen
);
  import lspd_pkg::*;

  // a held result keeps its word
  `LSPD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_left_drive) && $stable(out_right_drive) && $stable(out_position_error) && $stable(out_dark_count) && $stable(out_mark_seen), "stalled result changed")

  // input only backs up behind a stalled result
  `LSPD_ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output backpressure")

  `LSPD_ASSERT_NEXT(a_accept_out, in_valid && !in_stall, out_valid, "accepted word produced no result")

  `LSPD_ASSERT_IMPL(a_result_range, out_valid, out_dark_count <= MAX_DARK && $signed(out_position_error) <= ERR_MAX && $signed(out_position_error) >= -ERR_MAX, "result field out of range")

endmodule

bind line_sensor_steering_pd_core lspd_checker u_lspd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_left_drive     (out_left_drive),
  .out_right_drive    (out_right_drive),
  .out_position_error (out_position_error),
  .out_dark_count     (out_dark_count),
  .out_mark_seen      (out_mark_seen)
);

// ===== bench/tb.sv =====
// Self-checking bench for line_sensor_steering_pd_core: sensor bar readings in, PD drive out.
// Depends on lspd_pkg and the core; the expected results are computed here and
// compared word by word as they leave the block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lspd_pkg::*;

  localparam int STALL_LIMIT   = 2000;  // cycles with no handshake at all
  localparam int RANDOM_PER_SET = 280;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // not decoded by the block

  // sensor numbers 1..8 in priority order, and the error each one gives
  localparam int OUTER_SEQ [8] = '{4, 5, 3, 6, 7, 2, 8, 1};
  localparam int OUTER_ERR [8] = '{1, -1, 3, -3, -5, 5, -7, 7};
  localparam int INNER_SEQ [8] = '{4, 5, 3, 6, 2, 7, 1, 8};
  localparam int INNER_ERR [8] = '{5, -5, 9, -9, 11, -11, 12, -12};

  typedef struct {
    logic [7:0] lo;
    logic [7:0] hi;
    logic       md;
  } bar_reading_t;

  typedef struct {
    logic [7:0] left;
    logic [7:0] right;
    err_t       err;
    logic [3:0] cnt;
    logic       mark;
  } steer_out_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic       in_valid            = 1'b0;
  logic       in_stall;
  logic [7:0] in_sensor_low_byte  = 8'h00;
  logic [7:0] in_sensor_high_byte = 8'h00;
  logic       in_mode             = 1'b0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DRIVE_W-1:0]   out_left_drive;
  logic [DRIVE_W-1:0]   out_right_drive;
  logic signed [ERR_W-1:0] out_position_error;
  logic [CNT_W-1:0]     out_dark_count;
  logic                 out_mark_seen;

  line_sensor_steering_pd_core i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sensor_low_byte  (in_sensor_low_byte),
    .in_sensor_high_byte (in_sensor_high_byte),
    .in_mode             (in_mode),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_left_drive      (out_left_drive),
    .out_right_drive     (out_right_drive),
    .out_position_error  (out_position_error),
    .out_dark_count      (out_dark_count),
    .out_mark_seen       (out_mark_seen)
  );

  // predictor copy of the registers and the error memory
  int cfg_outer_base = 42;
  int cfg_inner_base = 40;
  int cfg_mark_thr   = 4;
  int steer_prev_err = 0;

  bar_reading_t reading_queue [$];
  steer_out_t   steer_expect [$];
  bar_reading_t next_rd;

  bit calm = 1'b0;
  int src_gap = 0;
  int sink_gap = 0;
  int idle_cycles = 0;
  int fail_count = 0;
  int readings_sent = 0;
  int results_checked = 0;
  int clamp_hits = 0;
  int marks_seen = 0;
  int settings_run = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int clamp8(input int v);
    if (v < 0) begin
      clamp_hits++;
      return 0;
    end
    if (v > 255) begin
      clamp_hits++;
      return 255;
    end
    return v;
  endfunction

  // expected result of one reading; advances the error memory
  function automatic steer_out_t steer_predict(input logic [7:0] lo, input logic [7:0] hi,
                                               input logic md);
    steer_out_t r;
    logic [8:1] dark;
    int cnt, e, base, gain, adj, k;
    bit found;
    dark[8] = (lo == 8'h00);
    for (k = 1; k <= 7; k++) begin
      dark[k] = ~hi[k];
    end
    cnt = $countones(dark);
    e = steer_prev_err;
    found = 1'b0;
    for (k = 0; k < 8; k++) begin
      if (!found) begin
        if (md == MODE_INNER && dark[INNER_SEQ[k]]) begin
          e = INNER_ERR[k];
          found = 1'b1;
        end else if (md == MODE_OUTER && dark[OUTER_SEQ[k]]) begin
          e = OUTER_ERR[k];
          found = 1'b1;
        end
      end
    end
    base = (md == MODE_INNER) ? cfg_inner_base : cfg_outer_base;
    gain = (md == MODE_INNER) ? 2 : 4;
    adj = e * gain + (e - steer_prev_err);
    steer_prev_err = e;
    r.left  = 8'(clamp8(base - adj));
    r.right = 8'(clamp8(base + adj));
    r.err   = ERR_W'(e);
    r.cnt   = 4'(cnt);
    r.mark  = (cnt > cfg_mark_thr);
    return r;
  endfunction

  // mostly a line crossing one to three neighboring sensors, some blank bar, some noise
  function automatic bar_reading_t make_reading();
    bar_reading_t rd;
    int pick, s, w, k;
    pick = $urandom_range(0, 99);
    rd.md = 1'($urandom_range(0, 1));
    if (pick < 65) begin
      s = $urandom_range(1, 8);
      w = $urandom_range(1, 3);
      rd.hi = {7'h7F, 1'($urandom_range(0, 1))};
      rd.lo = 8'($urandom_range(1, 255));
      for (k = s; k <= s + w - 1 && k <= 8; k++) begin
        if (k == 8) begin
          rd.lo = 8'h00;
        end else begin
          rd.hi[k] = 1'b0;
        end
      end
    end else if (pick < 80) begin
      rd.hi = {7'h7F, 1'($urandom_range(0, 1))};
      rd.lo = 8'($urandom_range(1, 255));
    end else begin
      rd.hi = 8'($urandom_range(0, 255));
      rd.lo = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
    end
    return rd;
  endfunction

  task automatic push_reading(input logic [7:0] lo, input logic [7:0] hi, input logic md);
    bar_reading_t rd;
    rd.lo = lo;
    rd.hi = hi;
    rd.md = md;
    reading_queue.push_back(rd);
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    fail_count++;
  endtask

  // one write per edge; the block is idle, so the local copy can change at once
  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_OUTER_BASE:  cfg_outer_base = int'(data);
      REG_INNER_BASE:  cfg_inner_base = int'(data);
      REG_MARK_THRESH: cfg_mark_thr   = int'(data[THR_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic reg_write_done();
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (reading_queue.size() != 0 || in_valid || steer_expect.size() != 0);
  endtask

  task automatic queue_random(input int n);
    repeat (n) reading_queue.push_back(make_reading());
  endtask

  // driver: holds a word while stalled, otherwise idles or loads the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        steer_expect.push_back(steer_predict(in_sensor_low_byte, in_sensor_high_byte,
                                             in_mode));
        readings_sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (reading_queue.size() > 0) begin
          next_rd = reading_queue.pop_front();
          in_sensor_low_byte  <= next_rd.lo;
          in_sensor_high_byte <= next_rd.hi;
          in_mode             <= next_rd.md;
          in_valid            <= 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 9);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_result();
    steer_out_t want;
    if (steer_expect.size() == 0) begin
      report_mismatch("result word with nothing outstanding");
    end else begin
      want = steer_expect.pop_front();
      results_checked++;
      if (out_mark_seen === 1'b1) marks_seen++;
      if (out_left_drive !== want.left)
        report_mismatch($sformatf("left_drive got %0d expected %0d",
                                  out_left_drive, want.left));
      if (out_right_drive !== want.right)
        report_mismatch($sformatf("right_drive got %0d expected %0d",
                                  out_right_drive, want.right));
      if (out_position_error !== want.err)
        report_mismatch($sformatf("position_error got %0d expected %0d",
                                  out_position_error, want.err));
      if (out_dark_count !== want.cnt)
        report_mismatch($sformatf("dark_count got %0d expected %0d",
                                  out_dark_count, want.cnt));
      if (out_mark_seen !== want.mark)
        report_mismatch($sformatf("mark_seen got %0d expected %0d",
                                  out_mark_seen, want.mark));
    end
  endtask

  // monitor and sink back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (sink_gap > 0) begin
        sink_gap--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        sink_gap = $urandom_range(0, 8);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("Watchdog: no handshake for %0d cycles, %0d words outstanding",
             STALL_LIMIT, steer_expect.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int s;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: each sensor alone in both modes, bit 0 of the high byte toggled
    for (s = 1; s <= 8; s++) begin
      push_reading((s == 8) ? 8'h00 : 8'hFF,
                   (s == 8) ? 8'hFF : (8'hFF & ~(8'h01 << s)) ^ 8'(s & 1), MODE_OUTER);
    end
    for (s = 1; s <= 8; s++) begin
      push_reading((s == 8) ? 8'h00 : 8'h01,
                   (s == 8) ? 8'hFE : (8'hFF & ~(8'h01 << s)) ^ 8'(s & 1), MODE_INNER);
    end
    push_reading(8'h01, 8'hFF, MODE_OUTER);   // blank bar keeps the last error
    push_reading(8'hFF, 8'hFE, MODE_INNER);
    push_reading(8'h80, 8'hE1, MODE_OUTER);   // four dark: at the threshold
    push_reading(8'h80, 8'hC1, MODE_INNER);   // five dark: above it
    push_reading(8'h00, 8'h00, MODE_OUTER);   // whole bar dark
    push_reading(8'h00, 8'h01, MODE_INNER);
    queue_random(RANDOM_PER_SET);
    wait_drained();
    settings_run++;

    // all zero: at least one side sits at the floor, any dark sensor is a mark
    reg_write(REG_OUTER_BASE, 8'd0);
    reg_write(REG_INNER_BASE, 8'd0);
    reg_write(REG_MARK_THRESH, 8'd0);
    reg_write_done();
    queue_random(RANDOM_PER_SET);
    wait_drained();

    // full scale; threshold eight means no mark can be seen
    reg_write(REG_OUTER_BASE, 8'd255);
    reg_write(REG_INNER_BASE, 8'd255);
    reg_write(REG_MARK_THRESH, 8'd8);
    reg_write_done();
    queue_random(RANDOM_PER_SET);
    wait_drained();

    // threshold above eight, upper data bits junk, undecoded index poked
    reg_write(REG_OUTER_BASE, 8'($urandom_range(0, 255)));
    reg_write(REG_INNER_BASE, 8'($urandom_range(0, 255)));
    reg_write(REG_MARK_THRESH, {4'($urandom_range(0, 15)), 4'($urandom_range(9, 15))});
    reg_write(REG_SPARE, 8'($urandom_range(0, 255)));
    reg_write_done();
    queue_random(RANDOM_PER_SET);
    wait_drained();

    reg_write(REG_SPARE, 8'h00);
    reg_write(REG_OUTER_BASE, 8'($urandom_range(0, 255)));
    reg_write(REG_INNER_BASE, 8'($urandom_range(0, 255)));
    reg_write(REG_MARK_THRESH, 8'($urandom_range(0, 8)));
    reg_write(REG_SPARE, 8'hFF);
    reg_write_done();
    queue_random(RANDOM_PER_SET);
    wait_drained();

    // back to back, no idling on either side
    calm = 1'b1;
    reg_write(REG_OUTER_BASE, 8'($urandom_range(20, 120)));
    reg_write(REG_INNER_BASE, 8'($urandom_range(20, 120)));
    reg_write(REG_MARK_THRESH, 8'($urandom_range(0, 15)));
    reg_write_done();
    queue_random(RANDOM_PER_SET);
    wait_drained();
    repeat (4) @(posedge clk);

    if (steer_expect.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", steer_expect.size()));

    $display("Covered %0d bar readings under %0d register settings, %0d results checked",
             readings_sent, settings_run, results_checked);
    $display("Clamped drive values: %0d, cross marks reported: %0d", clamp_hits, marks_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== line_sensor_steering_pd_core.f =====
+incdir+sv
sv/lspd_pkg.sv
sv/line_sensor_steering_pd_core.sv
sv/lspd_checker.sv
bench/tb.sv
